/* design/npc_pkg.sv */
// Shared types and constants for the NDN packet classifier.
`default_nettype none
package npc_pkg;

    localparam int OffsetWidth = 7;
    localparam int LenWidth    = OffsetWidth + 1;
    localparam int FifoDepth   = 2;

    localparam logic [OffsetWidth-1:0] OFFSET_MAX = {OffsetWidth{1'b1}};

    localparam logic [15:0] ETHTYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETHTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHTYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;

    localparam logic [15:0] NDN_ETHERTYPE_RESET = 16'h8624;
    localparam logic [15:0] NDN_UDP_PORT_RESET  = 16'd6363;

    // Ethernet header bytes, untagged and with one 802.1Q tag
    localparam logic [OffsetWidth-1:0] L2_UNTAGGED = 7'd14;
    localparam logic [OffsetWidth-1:0] L2_TAGGED   = 7'd18;
    localparam logic [LenWidth-1:0]    IPV4_HDR    = 8'd20;
    localparam logic [LenWidth-1:0]    IPV6_HDR    = 8'd40;
    localparam logic [LenWidth-1:0]    UDP_HDR     = 8'd8;

    // config register indexes
    localparam logic CFG_NDN_ETHERTYPE = 1'b0;
    localparam logic CFG_NDN_UDP_PORT  = 1'b1;

    typedef enum logic [1:0] {
        NET_NONE = 2'd0,
        NET_IPV4 = 2'd1,
        NET_IPV6 = 2'd2
    } net_kind_t;

    typedef enum logic [1:0] {
        VERDICT_PASS     = 2'd0,
        VERDICT_REDIRECT = 2'd1,
        VERDICT_TRUNC    = 2'd2
    } verdict_t;

    // everything the verdict needs, gathered by the parser at end of frame
    typedef struct packed {
        logic [LenWidth-1:0] len;
        logic                tag_seen;
        logic [15:0]         type_field;
        net_kind_t           net_kind;
        logic                is_udp;
        logic [15:0]         port_field;
    } frame_sum_t;

endpackage
`default_nettype wire

/* design/ndn_packet_classifier.sv */
// NDN packet classifier: one frame byte per cycle in, one verdict per frame out.
//
// Frames enter one byte per cycle on the s_axis side, tlast on the final byte,
// with no gap needed between frames. Each frame yields exactly one verdict on
// m_axis: 0 pass to stack, 1 redirect (NDN EtherType, or IPv4/IPv6 UDP to the
// NDN port), 2 truncated. The parser keeps pace with the input at one byte per
// cycle while s_axis_tready is high. The frame summary is queued when the last
// byte is taken, then loaded into the verdict register once the output is free.
// A two-entry summary queue sits between parser and verdict stage, so
// s_axis_tready drops only when both entries are held by a stalled output. IPv4
// options are not parsed (20-byte header assumed).
// Configuration writes are taken at any time but should be made while idle.
`default_nettype none
module ndn_packet_classifier
    import npc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [1:0] verdict, [7:2] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [15:0] ndn_ethertype_reg;
    logic [15:0] ndn_udp_port_reg;

    logic        sum_push;
    frame_sum_t  sum_in;
    logic        fifo_not_full;
    logic        sum_pop;
    frame_sum_t  sum_head;
    logic        fifo_not_empty;
    verdict_t    verdict;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ndn_ethertype_reg <= NDN_ETHERTYPE_RESET;
            ndn_udp_port_reg  <= NDN_UDP_PORT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_NDN_ETHERTYPE: ndn_ethertype_reg <= cfg_data;
                CFG_NDN_UDP_PORT:  ndn_udp_port_reg  <= cfg_data;
                default:           ndn_udp_port_reg  <= ndn_udp_port_reg;
            endcase
        end
    end

    npc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .sum_push  (sum_push),
        .sum_data  (sum_in),
        .sum_ready (fifo_not_full)
    );

    npc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (sum_push),
        .push_data (sum_in),
        .not_full  (fifo_not_full),
        .pop       (sum_pop),
        .head_data (sum_head),
        .not_empty (fifo_not_empty)
    );

    npc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .sum_valid     (fifo_not_empty),
        .sum_data      (sum_head),
        .sum_pop       (sum_pop),
        .ndn_ethertype (ndn_ethertype_reg),
        .ndn_udp_port  (ndn_udp_port_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_verdict   (verdict)
    );

    assign m_axis_tdata = {6'b0, verdict};

endmodule
`default_nettype wire

/* design/npc_front.sv */
// Byte-serial header parser: tracks offset and captures the header fields.
`default_nettype none
module npc_front
    import npc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            sum_push,
    output frame_sum_t      sum_data,
    input  wire logic       sum_ready
);

    logic [OffsetWidth-1:0] offset_reg, offset_next;
    logic [15:0]            type_reg, type_next;
    logic                   tag_reg, tag_next;
    net_kind_t              kind_reg, kind_next;
    logic [7:0]             proto_reg, proto_next;
    logic [15:0]            port_reg, port_next;

    logic                   accept;
    logic [OffsetWidth-1:0] p;
    logic [OffsetWidth-1:0] l2;
    logic [OffsetWidth-1:0] proto_at;
    logic [OffsetWidth-1:0] port_at;

    assign in_ready = sum_ready;
    assign accept   = in_valid && in_ready;
    assign p        = offset_reg;

    always_comb
    begin
        type_next  = type_reg;
        tag_next   = tag_reg;
        kind_next  = kind_reg;
        proto_next = proto_reg;
        port_next  = port_reg;

        if (p == 7'd12 || (tag_reg && p == 7'd16))
        begin
            type_next[15:8] = in_byte;
        end
        else if (p == 7'd13 || (tag_reg && p == 7'd17))
        begin
            type_next[7:0] = in_byte;
        end

        if (p == 7'd13 && type_next == ETHTYPE_VLAN)
        begin
            tag_next = 1'b1;
        end

        l2 = tag_next ? L2_TAGGED : L2_UNTAGGED;
        if (p + 7'd1 == l2)
        begin
            if (type_next == ETHTYPE_IPV4)
                kind_next = NET_IPV4;
            else if (type_next == ETHTYPE_IPV6)
                kind_next = NET_IPV6;
            else
                kind_next = NET_NONE;
        end

        // protocol sits at +9 (IPv4) or +6 (IPv6); dest port at header end + 2
        proto_at = l2 + ((kind_next == NET_IPV4) ? 7'd9 : 7'd6);
        port_at  = l2 + ((kind_next == NET_IPV4) ? 7'd22 : 7'd42);
        if (kind_next == NET_IPV4 || kind_next == NET_IPV6)
        begin
            if (p == proto_at)
                proto_next = in_byte;
            else if (p == port_at)
                port_next[15:8] = in_byte;
            else if (p == port_at + 7'd1)
                port_next[7:0] = in_byte;
        end

        offset_next = (offset_reg < OFFSET_MAX) ? offset_reg + 7'd1 : offset_reg;
    end

    assign sum_push            = accept && in_last;
    assign sum_data.len        = {1'b0, p} + 8'd1;
    assign sum_data.tag_seen   = tag_next;
    assign sum_data.type_field = type_next;
    assign sum_data.net_kind   = kind_next;
    assign sum_data.is_udp     = (proto_next == PROTO_UDP);
    assign sum_data.port_field = port_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            type_reg   <= '0;
            tag_reg    <= 1'b0;
            kind_reg   <= NET_NONE;
            proto_reg  <= '0;
            port_reg   <= '0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                offset_reg <= '0;
                type_reg   <= '0;
                tag_reg    <= 1'b0;
                kind_reg   <= NET_NONE;
                proto_reg  <= '0;
                port_reg   <= '0;
            end
            else
            begin
                offset_reg <= offset_next;
                type_reg   <= type_next;
                tag_reg    <= tag_next;
                kind_reg   <= kind_next;
                proto_reg  <= proto_next;
                port_reg   <= port_next;
            end
        end
    end

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |=> (offset_reg == '0 && !tag_reg && kind_reg == NET_NONE))
        else $error("parser state not cleared after frame end");

endmodule
`default_nettype wire

/* design/npc_fifo.sv */
// Short queue of frame summaries between parser and verdict stage.
`default_nettype none
module npc_fifo
    import npc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  frame_sum_t      push_data,
    output logic            not_full,
    input  wire logic       pop,
    output frame_sum_t      head_data,
    output logic            not_empty
);

    localparam int PtrWidth = $clog2(FifoDepth);
    localparam int CntWidth = $clog2(FifoDepth + 1);

    frame_sum_t            mem_reg [FifoDepth];
    logic [PtrWidth-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CntWidth-1:0]   count_reg, count_next;

    assign not_full  = (count_reg != CntWidth'(FifoDepth));
    assign not_empty = (count_reg != '0);
    assign head_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CntWidth'(1);
        else if (pop && !push)
            count_next = count_reg - CntWidth'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PtrWidth'(FifoDepth - 1)) ? '0
                                                                      : wr_ptr_reg + PtrWidth'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrWidth'(FifoDepth - 1)) ? '0
                                                                      : rd_ptr_reg + PtrWidth'(1);
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (not_full || pop))
        else $error("summary queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("summary queue underflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntWidth'(FifoDepth))
        else $error("summary queue count out of range");

endmodule
`default_nettype wire

/* design/npc_back.sv */
// Verdict stage: checks bounds and config matches, holds the result register.
`default_nettype none
module npc_back
    import npc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        sum_valid,
    input  frame_sum_t       sum_data,
    output logic             sum_pop,
    input  wire logic [15:0] ndn_ethertype,
    input  wire logic [15:0] ndn_udp_port,
    output logic             out_valid,
    input  wire logic        out_ready,
    output verdict_t         out_verdict
);

    logic                out_valid_reg;
    verdict_t            verdict_reg, verdict_next;
    logic [LenWidth-1:0] l2;
    logic [LenWidth-1:0] ip_end;

    always_comb
    begin
        l2     = sum_data.tag_seen ? {1'b0, L2_TAGGED} : {1'b0, L2_UNTAGGED};
        ip_end = l2 + ((sum_data.net_kind == NET_IPV4) ? IPV4_HDR : IPV6_HDR);

        priority if (sum_data.len < l2)
            verdict_next = VERDICT_TRUNC;
        else if (sum_data.type_field == ndn_ethertype)
            verdict_next = VERDICT_REDIRECT;
        else if (sum_data.net_kind != NET_IPV4 && sum_data.net_kind != NET_IPV6)
            verdict_next = VERDICT_PASS;
        else if (sum_data.len < ip_end)
            verdict_next = VERDICT_TRUNC;
        else if (!sum_data.is_udp)
            verdict_next = VERDICT_PASS;
        else if (sum_data.len < ip_end + UDP_HDR)
            verdict_next = VERDICT_TRUNC;
        else if (sum_data.port_field == ndn_udp_port)
            verdict_next = VERDICT_REDIRECT;
        else
            verdict_next = VERDICT_PASS;
    end

    assign sum_pop     = sum_valid && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;
    assign out_verdict = verdict_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (sum_pop)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (sum_pop)
            verdict_reg <= verdict_next;
    end

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (verdict_reg == VERDICT_PASS || verdict_reg == VERDICT_REDIRECT
                           || verdict_reg == VERDICT_TRUNC))
        else $error("undefined verdict code on output");

endmodule
`default_nettype wire

/* sim/ndn_packet_classifier_tb.sv */
// Self-checking testbench for the NDN packet classifier: frame stimulus and verdict scoreboard.
`timescale 1ns / 100ps
module ndn_packet_classifier_tb;
    import npc_pkg::*;

    localparam int CycleLimit = 200000;

    // frame shapes the generator can build
    localparam int FK_NDN   = 0;
    localparam int FK_IPV4  = 1;
    localparam int FK_IPV6  = 2;
    localparam int FK_OTHER = 3;
    localparam int FK_VLAN  = 4;    // inner type is another 802.1Q tag
    localparam int FK_NOISE = 5;    // random bytes only

    // Tracks the classifier's per-frame parse state and queues the verdict each frame earns.
    class verdict_scoreboard;
        logic [15:0]            ndn_type;
        logic [15:0]            ndn_port;
        logic [OffsetWidth-1:0] offset;
        logic [15:0]            type_f;
        logic                   has_tag;
        net_kind_t              kind;
        logic [7:0]             proto;
        logic [15:0]            port_f;
        verdict_t               expected_q[$];
        int                     errors;
        int                     verdict_count[3];

        function new();
            ndn_type = NDN_ETHERTYPE_RESET;
            ndn_port = NDN_UDP_PORT_RESET;
            offset   = '0;
            type_f   = '0;
            has_tag  = 1'b0;
            kind     = NET_NONE;
            proto    = '0;
            port_f   = '0;
            errors   = 0;
            verdict_count = '{0, 0, 0};
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            int       p;
            int       l2;
            int       hdr;
            int       proto_at;
            int       port_at;
            int       len;
            verdict_t v;
            p = offset;
            if (p == 12 || (has_tag && p == 16))
                type_f[15:8] = b;
            else if (p == 13 || (has_tag && p == 17))
                type_f[7:0] = b;
            if (p == 13 && type_f == ETHTYPE_VLAN)
                has_tag = 1'b1;
            l2 = has_tag ? 18 : 14;
            if (p + 1 == l2)
            begin
                if (type_f == ETHTYPE_IPV4)
                    kind = NET_IPV4;
                else if (type_f == ETHTYPE_IPV6)
                    kind = NET_IPV6;
                else
                    kind = NET_NONE;
            end
            hdr = (kind == NET_IPV4) ? 20 : 40;
            if (kind != NET_NONE)
            begin
                proto_at = l2 + ((kind == NET_IPV4) ? 9 : 6);
                port_at  = l2 + hdr + 2;
                if (p == proto_at)
                    proto = b;
                else if (p == port_at)
                    port_f[15:8] = b;
                else if (p == port_at + 1)
                    port_f[7:0] = b;
            end
            if (offset != OFFSET_MAX)
                offset = offset + 1'b1;
            if (!last)
                return;
            len = p + 1;
            if (len < l2)
                v = VERDICT_TRUNC;
            else if (type_f == ndn_type)
                v = VERDICT_REDIRECT;
            else if (kind == NET_NONE)
                v = VERDICT_PASS;
            else if (len < l2 + hdr)
                v = VERDICT_TRUNC;
            else if (proto != PROTO_UDP)
                v = VERDICT_PASS;
            else if (len < l2 + hdr + 8)
                v = VERDICT_TRUNC;
            else
                v = (port_f == ndn_port) ? VERDICT_REDIRECT : VERDICT_PASS;
            expected_q.push_back(v);
            offset  = '0;
            type_f  = '0;
            has_tag = 1'b0;
            kind    = NET_NONE;
            proto   = '0;
            port_f  = '0;
        endfunction

        function void check_verdict(logic [7:0] data);
            verdict_t   exp_v;
            logic [7:0] want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: verdict with no frame outstanding: expected none, actual 0x%02h",
                         $time, data);
                return;
            end
            exp_v = expected_q.pop_front();
            want  = {6'b0, exp_v};
            verdict_count[int'(exp_v)]++;
            if (data !== want)
            begin
                errors++;
                $display("%0t: verdict mismatch: expected 0x%02h (%s), actual 0x%02h",
                         $time, want, exp_v.name(), data);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] frame_byte
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [1:0] verdict, [7:2] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_NDN_ETHERTYPE;
    logic [15:0] cfg_data = '0;

    verdict_scoreboard sb = new();
    logic [7:0]        frame_buf[$];
    bit                src_burst;
    bit                burst_all;
    bit                hold_sink;
    int                bytes_sent;
    int                frames_sent;
    int                settings_used;
    int                cycles;

    ndn_packet_classifier i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("%0t: timeout after %0d cycles, %0d verdicts outstanding",
                     $time, cycles, sb.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Builds one frame in frame_buf. cut > 0 trims to that length, cut < 0 trims randomly.
    function automatic void build_frame(int kind, bit add_tag, bit udp, bit port_hit,
                                        int extra, int cut);
        logic [15:0] ether_type;
        int          start;
        int          hdr;
        frame_buf.delete();
        if (kind != FK_NOISE)
        begin
            repeat (12) frame_buf.push_back(8'($urandom));
            if (add_tag)
            begin
                frame_buf.push_back(ETHTYPE_VLAN[15:8]);
                frame_buf.push_back(ETHTYPE_VLAN[7:0]);
                repeat (2) frame_buf.push_back(8'($urandom));
            end
            case (kind)
                FK_NDN:  ether_type = sb.ndn_type;
                FK_IPV4: ether_type = ETHTYPE_IPV4;
                FK_IPV6: ether_type = ETHTYPE_IPV6;
                FK_VLAN: ether_type = ETHTYPE_VLAN;
                default: ether_type = 16'($urandom);
            endcase
            frame_buf.push_back(ether_type[15:8]);
            frame_buf.push_back(ether_type[7:0]);
            if (kind == FK_IPV4 || kind == FK_IPV6)
            begin
                hdr   = (kind == FK_IPV4) ? 20 : 40;
                start = frame_buf.size();
                repeat (hdr) frame_buf.push_back(8'($urandom));
                start += (kind == FK_IPV4) ? 9 : 6;
                frame_buf[start] = udp ? PROTO_UDP : 8'($urandom);
                if (!udp && frame_buf[start] == PROTO_UDP)
                    frame_buf[start] = 8'd6;
                if (udp)
                begin
                    start = frame_buf.size();
                    repeat (8) frame_buf.push_back(8'($urandom));
                    if (port_hit)
                    begin
                        frame_buf[start + 2] = sb.ndn_port[15:8];
                        frame_buf[start + 3] = sb.ndn_port[7:0];
                    end
                end
            end
        end
        repeat (extra) frame_buf.push_back(8'($urandom));
        if (cut < 0 && frame_buf.size() > 1)
            cut = $urandom_range(1, frame_buf.size() - 1);
        while (cut > 0 && frame_buf.size() > cut)
            void'(frame_buf.pop_back());
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        src_burst = burst_all || ($urandom_range(0, 3) == 0);
        foreach (frame_buf[i])
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        frames_sent++;
    endtask

    task automatic send_random_frame();
        int r;
        int kind;
        int extra;
        bit tg;
        r     = $urandom_range(0, 99);
        tg    = ($urandom_range(0, 3) == 0);
        extra = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 100) : $urandom_range(0, 6);
        if (r < 10)
        begin
            kind  = FK_NOISE;
            extra = $urandom_range(1, 24);
        end
        else if (r < 25)
            kind = FK_NDN;
        else if (r < 50)
            kind = FK_IPV4;
        else if (r < 75)
            kind = FK_IPV6;
        else if (r < 85)
            kind = FK_OTHER;
        else
        begin
            kind = FK_VLAN;
            tg   = 1'b1;
        end
        build_frame(kind, tg, $urandom_range(0, 4) != 0, $urandom_range(0, 1) == 1,
                    extra, ($urandom_range(0, 4) == 0) ? -1 : 0);
        send_frame();
    endtask

    // Stop offering and let every outstanding verdict come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_config(input logic [15:0] ether_type, input logic [15:0] port);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_NDN_ETHERTYPE;
        cfg_data  <= ether_type;
        do @(posedge clk); while (!cfg_ready);
        sb.ndn_type = ether_type;
        cfg_index <= CFG_NDN_UDP_PORT;
        cfg_data  <= port;
        do @(posedge clk); while (!cfg_ready);
        sb.ndn_port = port;
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : verdict_sink
        int gap;
        bit snk_burst;
        snk_burst = 1'b0;
        forever
        begin
            if (hold_sink)
            begin
                hold_sink = 1'b0;
                gap = 400;
            end
            else
            begin
                if ($urandom_range(0, 7) == 0)
                    snk_burst = !snk_burst;
                gap = snk_burst ? 0 : $urandom_range(0, 13);
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            sb.check_verdict(m_axis_tdata);
        end
    end

    initial
    begin : stimulus
        int target;
        int n;
        logic [15:0] ether_type;
        logic [15:0] port;
        settings_used = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames under the reset configuration
        build_frame(FK_NOISE, 1'b0, 1'b0, 1'b0, 1, 0);   send_frame();   // single-byte frame
        build_frame(FK_NDN,   1'b0, 1'b0, 1'b0, 0, 13);  send_frame();   // short of EtherType
        build_frame(FK_NDN,   1'b0, 1'b0, 1'b0, 0, 0);   send_frame();   // bare 14-byte NDN
        build_frame(FK_NDN,   1'b1, 1'b0, 1'b0, 0, 17);  send_frame();   // tag cut short
        build_frame(FK_NDN,   1'b1, 1'b0, 1'b0, 0, 0);   send_frame();
        build_frame(FK_OTHER, 1'b0, 1'b0, 1'b0, 0, 0);   send_frame();
        build_frame(FK_IPV4,  1'b0, 1'b1, 1'b1, 0, 0);   send_frame();   // exact IPv4+UDP
        build_frame(FK_IPV4,  1'b0, 1'b1, 1'b1, 0, 33);  send_frame();   // IP header cut
        build_frame(FK_IPV4,  1'b0, 1'b0, 1'b0, 0, 0);   send_frame();   // non-UDP
        build_frame(FK_IPV4,  1'b0, 1'b1, 1'b1, 0, 41);  send_frame();   // UDP header cut
        build_frame(FK_IPV6,  1'b1, 1'b1, 1'b1, 0, 0);   send_frame();
        build_frame(FK_IPV6,  1'b0, 1'b1, 1'b0, 0, 0);   send_frame();
        build_frame(FK_VLAN,  1'b1, 1'b0, 1'b0, 4, 0);   send_frame();   // double tag
        build_frame(FK_IPV4,  1'b1, 1'b1, 1'b1, 110, 0); send_frame();   // offset saturates
        build_frame(FK_NOISE, 1'b0, 1'b0, 1'b0, 20, 0);
        foreach (frame_buf[i]) frame_buf[i] = 8'hFF;
        send_frame();
        build_frame(FK_NOISE, 1'b0, 1'b0, 1'b0, 20, 0);
        foreach (frame_buf[i]) frame_buf[i] = 8'h00;
        send_frame();
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin ether_type = 16'h0000;            port = 16'h0000;             end
                1: begin ether_type = 16'hFFFF;            port = 16'hFFFF;             end
                2: begin ether_type = ETHTYPE_IPV4;        port = 16'($urandom);        end
                3: begin ether_type = ETHTYPE_VLAN;        port = 16'($urandom);        end
                4: begin ether_type = 16'($urandom);       port = 16'($urandom);        end
                default: begin ether_type = NDN_ETHERTYPE_RESET; port = NDN_UDP_PORT_RESET; end
            endcase
            write_config(ether_type, port);
            target = bytes_sent + 50;
            n = 0;
            while (bytes_sent < target || n < 2)
            begin
                send_random_frame();
                n++;
            end
            if (ph == 2)
            begin
                // output stalls long enough for the summary queue to fill and block input
                hold_sink = 1'b1;
                burst_all = 1'b1;
                repeat (6)
                begin
                    build_frame(FK_NDN, 1'b0, 1'b0, 1'b0, 0, 0);
                    send_frame();
                end
                burst_all = 1'b0;
            end
            drain();
        end

        $display("Sent %0d frames (%0d bytes) under %0d register settings",
                 frames_sent, bytes_sent, settings_used);
        $display("Verdicts checked: %0d pass, %0d redirect, %0d truncated",
                 sb.verdict_count[0], sb.verdict_count[1], sb.verdict_count[2]);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
design/npc_pkg.sv
design/npc_front.sv
design/npc_fifo.sv
design/npc_back.sv
design/ndn_packet_classifier.sv
sim/ndn_packet_classifier_tb.sv
